/* rtl/assert_macros.svh */
// Assertion macros for the checker file of the list store.
// Depends on nothing; the using module must have clk and arst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is asserted.
`define ULST_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Clocked implication built on the macro above.
`define ULST_ASSERT_IMP(lbl, ante, cons, msg) \
	`ULST_ASSERT(lbl, (ante) |-> (cons), msg)

`endif

/* rtl/ulst_pkg.sv */
// Shared types, sizes and codes of the unordered list store.
// Depends on nothing; all files but ulst_ram and assert_macros.svh import it.
package ulst_pkg;

	localparam int CAPACITY   = 16;
	localparam int ELEM_WIDTH = 32;
	localparam int IDX_W      = $clog2(CAPACITY);
	localparam int CNT_W      = $clog2(CAPACITY + 1);

	typedef enum logic [1:0] {
		OP_APPEND = 2'd0,
		OP_SEARCH = 2'd1,
		OP_DELETE = 2'd2,
		OP_NONE   = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_MISSING = 2'd1,
		ST_FULL    = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_EXEC,
		S_SCAN,
		S_SHIFT,
		S_DONE
	} state_t;

	// Result of one operation as it travels to the output register.
	typedef struct packed {
		status_t          status;
		logic             found;
		logic [CNT_W-1:0] count;
		logic             empty;
	} res_t;

	// Port requests from the sequencer to the entry memory.
	typedef struct packed {
		logic                  we;
		logic [IDX_W-1:0]      waddr;
		logic [ELEM_WIDTH-1:0] wdata;
		logic [IDX_W-1:0]      raddr;
	} ram_req_t;

endpackage

/* rtl/ulst_ram.sv */
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Depends on nothing.
module ulst_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

/* rtl/ulst_ctrl.sv */
// Sequencer of the list store: walks the entry memory one entry a cycle with
// a single key comparator and moves entries down after a delete. Uses ulst_pkg.
module ulst_ctrl (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          req_valid,
	output logic                          req_stall,
	input  logic [1:0]                    func,
	input  logic [ulst_pkg::ELEM_WIDTH-1:0] key,
	input  logic [ulst_pkg::ELEM_WIDTH-1:0] rdata,
	output ulst_pkg::ram_req_t            ram_req,
	input  logic                          out_free,
	output logic                          done,
	output ulst_pkg::res_t                res
);
	import ulst_pkg::*;

	state_t                state_q, state_d;
	logic [CNT_W-1:0]      cnt_q;
	logic [CNT_W-1:0]      pos_q;
	logic [ELEM_WIDTH-1:0] key_q;
	op_t                   op_q;
	status_t               status_q;
	logic                  found_q;

	logic [CNT_W-1:0] nxt_pos;
	logic [CNT_W-1:0] two_ahead;
	logic             in_range;
	logic             hit;
	logic             full;
	logic             last;
	logic             accept;

	assign accept    = req_valid && !req_stall;
	assign nxt_pos   = CNT_W'(pos_q + 1'b1);
	assign two_ahead = CNT_W'(pos_q + CNT_W'(2));
	assign in_range  = pos_q < cnt_q;
	assign hit       = in_range && (rdata == key_q);
	assign full      = cnt_q == CNT_W'(CAPACITY);
	assign last      = nxt_pos >= cnt_q;

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					state_d = S_EXEC;
				end
			end
			S_EXEC: begin
				if (op_q == OP_SEARCH || op_q == OP_DELETE) begin
					state_d = S_SCAN;
				end else begin
					state_d = S_DONE;
				end
			end
			S_SCAN: begin
				if (!in_range) begin
					state_d = S_DONE;
				end else if (hit) begin
					state_d = (op_q == OP_DELETE) ? S_SHIFT : S_DONE;
				end
			end
			S_SHIFT: begin
				if (last) begin
					state_d = S_DONE;
				end
			end
			S_DONE: begin
				if (out_free) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// Outputs: memory port requests, handshake and result hand-off.
	always_comb begin
		ram_req   = '0;
		req_stall = 1'b1;
		done      = 1'b0;
		case (state_q)
			S_IDLE: begin
				req_stall = 1'b0;
			end
			S_EXEC: begin
				ram_req.raddr = '0;
				if (op_q == OP_APPEND && !full) begin
					ram_req.we    = 1'b1;
					ram_req.waddr = cnt_q[IDX_W-1:0];
					ram_req.wdata = key_q;
				end
			end
			S_SCAN: begin
				ram_req.raddr = nxt_pos[IDX_W-1:0];
			end
			S_SHIFT: begin
				ram_req.raddr = two_ahead[IDX_W-1:0];
				if (!last) begin
					ram_req.we    = 1'b1;
					ram_req.waddr = pos_q[IDX_W-1:0];
					ram_req.wdata = rdata;
				end
			end
			S_DONE: begin
				done = out_free;
			end
			default: begin
				req_stall = 1'b1;
			end
		endcase
	end

	assign res.status = status_q;
	assign res.found  = found_q;
	assign res.count  = cnt_q;
	assign res.empty  = cnt_q == '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == S_EXEC && op_q == OP_APPEND && !full) begin
				cnt_q <= CNT_W'(cnt_q + 1'b1);
			end else if (state_q == S_SHIFT && last) begin
				cnt_q <= CNT_W'(cnt_q - 1'b1);
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					op_q  <= op_t'(func);
					key_q <= key;
				end
			end
			S_EXEC: begin
				pos_q    <= '0;
				found_q  <= 1'b0;
				status_q <= (op_q == OP_APPEND && full) ? ST_FULL : ST_OK;
			end
			S_SCAN: begin
				if (!in_range) begin
					status_q <= ST_MISSING;
				end else if (hit) begin
					found_q <= 1'b1;
				end else begin
					pos_q <= nxt_pos;
				end
			end
			S_SHIFT: begin
				pos_q <= nxt_pos;
			end
			default: begin
				pos_q <= pos_q;
			end
		endcase
	end

endmodule

/* rtl/unordered_list_store_core.sv */
// Unordered list store: append, search and delete-with-shift over up to CAPACITY keys.
// Sequence: an accepted request enters EXEC; append and the unused code then go to DONE,
// while search and delete scan the entries in order from the head, and a delete that
// matches moves every later entry down one place before DONE; DONE hands the result on.
// One request at a time: req_stall holds until the result enters the output register.
// Reset (arst_n, asynchronous): the store reads as empty and no result is pending.
module unordered_list_store_core (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          req_valid,
	output logic                          req_stall,
	input  logic [1:0]                    func,
	input  logic [31:0]                   elem_value,
	output logic                          res_valid,
	input  logic                          res_stall,
	output logic [1:0]                    status,
	output logic                          found,
	output logic [4:0]                    count,
	output logic                          empty_res
);
	import ulst_pkg::*;

	// The key is the low ELEM_WIDTH bits of the incoming element value.
	logic [ELEM_WIDTH-1:0] key;
	logic [ELEM_WIDTH-1:0] rdata;
	ram_req_t              ram_req;
	res_t                  res;
	res_t                  res_q;
	logic                  res_valid_q;
	logic                  out_free;
	logic                  done;

	assign key = elem_value[ELEM_WIDTH-1:0];

	// The output register is free when it is empty or its beat leaves this cycle,
	// so a finished result never waits behind one that is being taken.
	assign out_free = !res_valid_q || !res_stall;

	// The sequencer owns the fill count and drives the single memory port pair.
	ulst_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.func     (func),
		.key      (key),
		.rdata    (rdata),
		.ram_req  (ram_req),
		.out_free (out_free),
		.done     (done),
		.res      (res)
	);

	// Entry memory: one write and one registered read per cycle. Entries past the
	// fill count are never compared, so the memory needs no clearing after reset.
	ulst_ram #(
		.WIDTH(ELEM_WIDTH),
		.DEPTH(CAPACITY)
	) u_ram (
		.clk  (clk),
		.we   (ram_req.we),
		.waddr(ram_req.waddr),
		.wdata(ram_req.wdata),
		.raddr(ram_req.raddr),
		.rdata(rdata)
	);

	// Output register: holds a result beat until the consumer takes it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (done) begin
			res_valid_q <= 1'b1;
		end else if (!res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (done) begin
			res_q <= res;
		end
	end

	assign res_valid = res_valid_q;
	assign status    = 2'(res_q.status);
	assign found     = res_q.found;
	assign count     = 5'(res_q.count);
	assign empty_res = res_q.empty;

endmodule

/* rtl/ulst_chk.sv */
// Port-level checker of the list store, bound to the top level.
// Depends on ulst_pkg and assert_macros.svh.
`include "assert_macros.svh"

module ulst_chk (
	input logic       clk,
	input logic       arst_n,
	input logic       res_valid,
	input logic       res_stall,
	input logic [1:0] status,
	input logic       found,
	input logic [4:0] count,
	input logic       empty_res
);
	import ulst_pkg::*;

	`ULST_ASSERT_IMP(a_empty_match, res_valid, empty_res == (count == 5'd0), "empty flag disagrees with count")
	`ULST_ASSERT_IMP(a_found_ok, res_valid && found, status == 2'(ST_OK), "found result without ok status")
	`ULST_ASSERT_IMP(a_full_count, res_valid && status == 2'(ST_FULL), count == 5'(CAPACITY), "full status below capacity")
	`ULST_ASSERT(a_res_hold, res_valid && res_stall |=> res_valid && $stable(count) && $stable(status), "stalled result changed")

endmodule

bind unordered_list_store_core ulst_chk u_chk (.*);

/* bench/list_store_checker.sv */
`timescale 1ns / 100ps
// Scoreboard for the unordered list store: watches the request and result channels,
// keeps a shadow copy of the list to predict each result, and compares field by field.
// Depends on ulst_pkg for the operation, status and result types.
module list_store_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        req_valid,
	input  logic        req_stall,
	input  logic [1:0]  func,
	input  logic [31:0] elem_value,
	input  logic        res_valid,
	input  logic        res_stall,
	input  logic [1:0]  status,
	input  logic        found,
	input  logic [4:0]  count,
	input  logic        empty_res,
	output int          fail_count,
	output int          pending,
	output int          results_checked,
	output int          full_rejects,
	output int          missing_keys,
	output int          empty_results
);
	import ulst_pkg::*;

	logic [ELEM_WIDTH-1:0] shadow_keys [CAPACITY];
	int                    shadow_fill;
	res_t                  awaited_results [$];

	// Applies one operation to the shadow list and returns the result it must produce.
	function automatic res_t apply_list_op(input op_t op, input logic [ELEM_WIDTH-1:0] key);
		res_t r;
		int   hit;
		r = '0;
		r.status = ST_OK;
		hit = -1;
		for (int i = 0; i < shadow_fill; i++)
			if (hit < 0 && shadow_keys[i] == key)
				hit = i;
		case (op)
			OP_APPEND: begin
				if (shadow_fill >= CAPACITY) begin
					r.status = ST_FULL;
				end else begin
					shadow_keys[shadow_fill] = key;
					shadow_fill++;
				end
			end
			OP_SEARCH: begin
				if (hit >= 0)
					r.found = 1'b1;
				else
					r.status = ST_MISSING;
			end
			OP_DELETE: begin
				if (hit >= 0) begin
					r.found = 1'b1;
					for (int i = hit; i < shadow_fill - 1; i++)
						shadow_keys[i] = shadow_keys[i + 1];
					shadow_fill--;
				end else begin
					r.status = ST_MISSING;
				end
			end
			default: ;
		endcase
		r.count = CNT_W'(shadow_fill);
		r.empty = (shadow_fill == 0);
		return r;
	endfunction

	initial begin
		shadow_fill = 0;
		fail_count = 0;
		pending = 0;
		results_checked = 0;
		full_rejects = 0;
		missing_keys = 0;
		empty_results = 0;
	end

	always @(posedge clk) begin
		res_t want;
		if (arst_n) begin
			// A result always trails its request, so checking first is safe.
			if (res_valid && !res_stall) begin
				if (awaited_results.size() == 0) begin
					$error("result beat with nothing awaited: status %0d count %0d",
						status, count);
					fail_count++;
				end else begin
					want = awaited_results.pop_front();
					results_checked++;
					if (status !== want.status) begin
						$error("field status expected %0d actual %0d", want.status, status);
						fail_count++;
					end
					if (found !== want.found) begin
						$error("field found expected %0d actual %0d", want.found, found);
						fail_count++;
					end
					if (count !== want.count) begin
						$error("field count expected %0d actual %0d", want.count, count);
						fail_count++;
					end
					if (empty_res !== want.empty) begin
						$error("field empty_res expected %0d actual %0d", want.empty, empty_res);
						fail_count++;
					end
				end
			end
			if (req_valid && !req_stall) begin
				want = apply_list_op(op_t'(func), elem_value);
				awaited_results.push_back(want);
				if (want.status == ST_FULL)
					full_rejects++;
				if (want.status == ST_MISSING)
					missing_keys++;
				if (want.empty)
					empty_results++;
			end
			pending = awaited_results.size();
		end
	end

endmodule

/* bench/testbench.sv */
`timescale 1ns / 100ps
// Top of the list store bench: clock, reset, paced request stimulus and a stalling
// result sink around u_top; list_store_checker does all prediction and comparison.
// Depends on ulst_pkg, unordered_list_store_core and list_store_checker.
module testbench;
	import ulst_pkg::*;

	// Number of random request beats after the directed opening.
	localparam int RANDOM_BEATS = 1800;
	// The limit covers the worst correct run of roughly 1830 beats, each with the longest
	// block operation, a long sink stall and a sender gap, and leaves plenty of margin.
	localparam int CYCLE_LIMIT  = 900000;
	// Cycles to keep watching after the last result, past the longest operation.
	localparam int DRAIN_CYCLES = 48;
	localparam int POOL_SIZE    = 12;

	// Receiver behaviors; each one holds for a random stretch of cycles.
	typedef enum int {
		SINK_OPEN,
		SINK_LIGHT,
		SINK_HEAVY,
		SINK_BLOCKED
	} sink_mode_t;

	logic        clk;
	logic        arst_n;
	logic        req_valid;
	logic        req_stall;
	logic [1:0]  func;
	logic [31:0] elem_value;
	logic        res_valid;
	logic        res_stall;
	logic [1:0]  status;
	logic        found;
	logic [4:0]  count;
	logic        empty_res;

	int fail_count;
	int pending;
	int results_checked;
	int full_rejects;
	int missing_keys;
	int empty_results;

	int          cycle_count;
	int          beats_sent;
	int          burst_left;
	bit          quiet_sender;
	logic [31:0] key_pool [POOL_SIZE];

	unordered_list_store_core u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (req_valid),
		.req_stall  (req_stall),
		.func       (func),
		.elem_value (elem_value),
		.res_valid  (res_valid),
		.res_stall  (res_stall),
		.status     (status),
		.found      (found),
		.count      (count),
		.empty_res  (empty_res)
	);

	list_store_checker u_checker (
		.clk             (clk),
		.arst_n          (arst_n),
		.req_valid       (req_valid),
		.req_stall       (req_stall),
		.func            (func),
		.elem_value      (elem_value),
		.res_valid       (res_valid),
		.res_stall       (res_stall),
		.status          (status),
		.found           (found),
		.count           (count),
		.empty_res       (empty_res),
		.fail_count      (fail_count),
		.pending         (pending),
		.results_checked (results_checked),
		.full_rejects    (full_rejects),
		.missing_keys    (missing_keys),
		.empty_results   (empty_results)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Watchdog: a hung handshake or a lost result ends the run here.
	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("Run stopped after %0d cycles with %0d results still awaited.",
			cycle_count, pending);
		$display("status: fail");
		$finish;
	end

	// Result sink. The stall pattern switches between open stretches, light and heavy
	// random stalling, and solid blocks, so stalls land on every phase of the block's
	// scan and shift work. It changes only at the falling edge.
	initial begin
		sink_mode_t mode;
		int         span;
		res_stall = 1'b0;
		forever begin
			mode = sink_mode_t'($urandom_range(0, 3));
			span = (mode == SINK_BLOCKED) ? $urandom_range(2, 30) : $urandom_range(4, 60);
			repeat (span) begin
				@(negedge clk);
				case (mode)
					SINK_OPEN:    res_stall = 1'b0;
					SINK_LIGHT:   res_stall = ($urandom_range(0, 99) < 30);
					SINK_HEAVY:   res_stall = ($urandom_range(0, 99) < 80);
					SINK_BLOCKED: res_stall = 1'b1;
					default:      res_stall = 1'b0;
				endcase
			end
		end
	end

	// Keys are mostly drawn from a small pool so that searches and deletes hit often
	// and duplicates pile up. The pool always holds the all-zero and all-one keys.
	task automatic refresh_key_pool();
		key_pool[0] = '0;
		key_pool[1] = '1;
		for (int i = 2; i < POOL_SIZE; i++)
			key_pool[i] = $urandom;
	endtask

	// Sends one request beat. The sender works in bursts: when a burst runs out, it
	// usually drops valid for a random gap before the next one starts. Valid stays
	// high between beats of one burst, and the payload holds while the block stalls.
	// Entered and left at a falling edge.
	task automatic send_beat(input op_t op, input logic [31:0] key);
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			if (!quiet_sender && $urandom_range(0, 3) != 0) begin
				req_valid = 1'b0;
				repeat ($urandom_range(1, 10)) @(negedge clk);
			end
		end
		burst_left--;
		req_valid  = 1'b1;
		func       = op;
		elem_value = key;
		do
			@(posedge clk);
		while (req_stall);
		@(negedge clk);
		beats_sent++;
	endtask

	initial begin
		int          phase;
		int          pick;
		op_t         op;
		logic [31:0] key;

		arst_n       = 1'b0;
		req_valid    = 1'b0;
		func         = OP_APPEND;
		elem_value   = '0;
		burst_left   = 0;
		quiet_sender = 1'b0;
		beats_sent   = 0;
		refresh_key_pool();

		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed opening. On the empty store: the unused code, then a search and a
		// delete that cannot match.
		send_beat(OP_NONE, 32'h1234_5678);
		send_beat(OP_SEARCH, 32'h0000_0000);
		send_beat(OP_DELETE, 32'hFFFF_FFFF);
		// Extreme keys, and a duplicate of the zero key.
		send_beat(OP_APPEND, 32'h0000_0000);
		send_beat(OP_APPEND, 32'hFFFF_FFFF);
		send_beat(OP_APPEND, 32'h0000_0000);
		send_beat(OP_SEARCH, 32'h0000_0000);
		// Fill the store to capacity with alternating bit patterns.
		for (int k = 3; k < CAPACITY; k++)
			send_beat(OP_APPEND, (k % 2) ? (32'hAAAA_AA00 | k) : (32'h5555_5500 | k));
		// Append to a full store, and the unused code while full.
		send_beat(OP_APPEND, 32'hDEAD_BEEF);
		send_beat(OP_NONE, 32'hFFFF_FFFF);
		send_beat(OP_SEARCH, 32'hFFFF_FFFF);
		// Delete at the head shifts every later entry; the duplicate must survive.
		send_beat(OP_DELETE, 32'h0000_0000);
		send_beat(OP_SEARCH, 32'h0000_0000);
		// Second delete takes the duplicate from the second position; then the last entry goes.
		send_beat(OP_DELETE, 32'h0000_0000);
		send_beat(OP_DELETE, 32'hAAAA_AA00 | (CAPACITY - 1));

		// Random part. The operation mix cycles through append-heavy, balanced and
		// delete-heavy phases so the store swings between full and empty many times.
		// Some windows run without sender gaps at all.
		for (int n = 0; n < RANDOM_BEATS; n++) begin
			if (n % 300 == 0)
				refresh_key_pool();
			quiet_sender = ((n % 500) < 80);
			phase = (n / 120) % 3;
			pick  = $urandom_range(0, 99);
			if (pick >= 97)
				op = OP_NONE;
			else if (pick < ((phase == 0) ? 55 : (phase == 1) ? 35 : 20))
				op = OP_APPEND;
			else if (pick < ((phase == 0) ? 75 : (phase == 1) ? 65 : 45))
				op = OP_SEARCH;
			else
				op = OP_DELETE;
			key = ($urandom_range(0, 3) == 0) ? $urandom :
				key_pool[$urandom_range(0, POOL_SIZE - 1)];
			send_beat(op, key);
		end
		req_valid = 1'b0;

		// Wait for every awaited result, then a little longer for stray beats.
		while (pending != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);

		$display("Sent %0d request beats and checked %0d results in %0d cycles.",
			beats_sent, results_checked, cycle_count);
		$display("Seen: %0d full-store rejects, %0d missing keys, %0d empty-store results.",
			full_rejects, missing_keys, empty_results);
		if (fail_count == 0 && pending == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
